>>> hw/rtl/bmgs_pkg.sv
// Box-Muller sampler shared constants and helpers.
// No dependencies.
package bmgs_pkg;

    localparam int UNIFORM_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int LOG_FRAC         = 28;

    localparam logic [31:0] TWO_LN2_Q28 = 32'd372130559;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

    localparam logic [0:0] REG_MEAN     = 1'd0;
    localparam logic [0:0] REG_VARIANCE = 1'd1;

    // Horner divisors: sine uses four steps, cosine five
    function automatic logic [6:0] horner_div(input logic is_cos, input logic [2:0] idx);
        logic [6:0] d;
        d = 7'd1;
        if (is_cos) begin
            case (idx)
                3'd0: d = 7'd90;
                3'd1: d = 7'd56;
                3'd2: d = 7'd30;
                3'd3: d = 7'd12;
                3'd4: d = 7'd2;
                default: d = 7'd1;
            endcase
        end else begin
            case (idx)
                3'd0: d = 7'd72;
                3'd1: d = 7'd42;
                3'd2: d = 7'd20;
                3'd3: d = 7'd6;
                default: d = 7'd1;
            endcase
        end
        return d;
    endfunction

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } unit_ctl_t;

endpackage

>>> hw/rtl/box_muller_gaussian_sampler_unit.sv
// Box-Muller Gaussian sampler top level; depends on bmgs_pkg and bmgs_core.
// A cosine half runs 28 log squarings, the bit-serial root steps and nine
// two-multiply Horner steps; a sine half uses the stored spare and skips the log.
// One item at a time, on the shared multiplier and the bit-serial root: no new
// transaction is taken until the result moves into the output register.
// Reset (aresetn, synchronous): spare cleared, mean 0, variance 1.0, no result.
module box_muller_gaussian_sampler_unit #(
    parameter int UNIFORM_BITS = bmgs_pkg::UNIFORM_BITS_DEF,
    parameter int FRAC_BITS    = bmgs_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_uniform_radius,
    input  logic [31:0] s_uniform_phase,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_gauss_sample,
    output logic        m_used_spare
);
    logic [31:0] mean_reg;
    logic [31:0] var_reg;
    logic        busy_reg;
    logic        mvalid_reg;
    logic        pend_reg;
    logic [31:0] samp_reg;
    logic        spare_reg;
    logic        core_done;
    logic [31:0] core_sample;
    logic        core_spare;
    logic        start;
    logic        res_avail;
    logic        out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = !busy_reg;
    assign start     = s_valid && s_ready;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg <= '0;
            var_reg  <= 32'd65536;
        end else if (cfg_valid) begin
            case (cfg_index)
                bmgs_pkg::REG_MEAN:     mean_reg <= cfg_data;
                bmgs_pkg::REG_VARIANCE: var_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    bmgs_core #(.UNIFORM_BITS(UNIFORM_BITS), .FRAC_BITS(FRAC_BITS)) u_core (
        .aclk(aclk), .aresetn(aresetn), .start(start),
        .u_radius(s_uniform_radius), .u_phase(s_uniform_phase),
        .mean_level(mean_reg), .variance_level(var_reg),
        .done(core_done), .sample(core_sample), .spare_flag(core_spare)
    );

    // core result waits in the core until the output register frees up
    assign res_avail = core_done || pend_reg;
    assign out_free  = !mvalid_reg || m_ready;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end else begin
            if (res_avail && out_free) begin
                busy_reg   <= 1'b0;
                pend_reg   <= 1'b0;
                mvalid_reg <= 1'b1;
                samp_reg   <= core_sample;
                spare_reg  <= core_spare;
            end else begin
                if (start) busy_reg <= 1'b1;
                if (core_done) pend_reg <= 1'b1;
                if (m_ready) mvalid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = mvalid_reg;
    assign m_gauss_sample = samp_reg;
    assign m_used_spare   = spare_reg;
endmodule

>>> hw/rtl/bmgs_divider.sv
// Division by a Horner constant through reciprocal multiplication.
// Depends on nothing but its ports; the product comes from the shared multiplier.
module bmgs_divider (
    input  logic [6:0]  denom,
    input  logic [63:0] prod,
    output logic [31:0] recip,
    output logic [30:0] quot
);
    // recip = ceil(2^s / d) with s = 30 + ceil(log2 d); exact for dividends below 2^30
    always_comb begin
        case (denom)
            7'd72: begin recip = 32'd1908874354; quot = 31'(prod >> 37); end
            7'd42: begin recip = 32'd1636178018; quot = 31'(prod >> 36); end
            7'd20: begin recip = 32'd1717986919; quot = 31'(prod >> 35); end
            7'd6:  begin recip = 32'd1431655766; quot = 31'(prod >> 33); end
            7'd90: begin recip = 32'd1527099484; quot = 31'(prod >> 37); end
            7'd56: begin recip = 32'd1227133514; quot = 31'(prod >> 36); end
            7'd30: begin recip = 32'd1145324613; quot = 31'(prod >> 35); end
            7'd12: begin recip = 32'd1431655766; quot = 31'(prod >> 34); end
            7'd2:  begin recip = 32'd1073741824; quot = 31'(prod >> 31); end
            default: begin recip = 32'h8000_0000; quot = 31'(prod >> 31); end
        endcase
    end
endmodule

>>> hw/rtl/bmgs_core.sv
// Sequencer over a shared 32x32 multiplier and a bit-serial square root.
// Depends on bmgs_pkg and bmgs_divider.
module bmgs_core #(
    parameter int UNIFORM_BITS = bmgs_pkg::UNIFORM_BITS_DEF,
    parameter int FRAC_BITS    = bmgs_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] u_radius,
    input  logic [31:0] u_phase,
    input  logic [31:0] mean_level,
    input  logic [31:0] variance_level,
    output logic        done,
    output logic [31:0] sample,
    output logic        spare_flag
);
    localparam int SH = 56 - FRAC_BITS;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LNORM = 5'd1;
    localparam logic [4:0] S_LSQ   = 5'd2;
    localparam logic [4:0] S_LMUL  = 5'd3;
    localparam logic [4:0] S_VMUL  = 5'd4;
    localparam logic [4:0] S_SQRT  = 5'd5;
    localparam logic [4:0] S_XMUL  = 5'd6;
    localparam logic [4:0] S_X2    = 5'd7;
    localparam logic [4:0] S_HMUL  = 5'd8;
    localparam logic [4:0] S_HDIV  = 5'd9;
    localparam logic [4:0] S_SMUL  = 5'd11;
    localparam logic [4:0] S_AMUL  = 5'd12;
    localparam logic [4:0] S_FIN   = 5'd13;
    localparam logic [4:0] S_LMUL2 = 5'd14;

    logic [4:0]  state_reg;
    logic        spare_valid_reg;
    logic [31:0] spare_r_reg;
    logic [31:0] spare_ph_reg;
    logic        want_sin_reg;
    logic [5:0]  e_reg;
    logic [31:0] m_reg;
    logic [27:0] frac_reg;
    logic [4:0]  it_reg;
    logic [63:0] acc_reg;
    logic [63:0] sq_v_reg;
    logic [63:0] sq_res_reg;
    logic [63:0] sq_bit_reg;
    logic [31:0] amp_reg;
    logic [29:0] f_reg;
    logic        swap_reg;
    logic [30:0] x_reg;
    logic [30:0] x2_reg;
    logic [30:0] t_reg;
    logic [30:0] sin_reg;
    logic        cos_pass_reg;
    logic [2:0]  hidx_reg;
    logic [31:0] out_reg;
    logic        done_reg;
    logic        spare_out_reg;

    // shared multiplier: 32x32 unsigned
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [31:0] div_recip;
    logic [30:0] div_q;

    // Horner division by a constant, done on the shared multiplier
    bmgs_divider u_div (
        .denom(bmgs_pkg::horner_div(cos_pass_reg, hidx_reg)),
        .prod(mul_p), .recip(div_recip), .quot(div_q)
    );

    logic [63:0] ux;
    logic [5:0]  e_find;
    logic [63:0] lval;
    logic [63:0] r_round;
    logic [29:0] fraw;
    logic [1:0]  quad;
    logic [30:0] sp;
    logic [30:0] cp;
    logic [30:0] tsel;
    logic        negv;
    logic [32:0] mag;
    logic signed [34:0] vsum;
    logic [63:0] sq_sum;

    always_comb begin
        ux = {32'd0, u_radius} & ((64'd1 << UNIFORM_BITS) - 64'd1);
        if (ux == 64'd0) ux = 64'd1;
        e_find = '0;
        for (int i = 0; i < 32; i++) begin
            if (ux[i]) e_find = 6'(i);
        end
        lval    = (64'(UNIFORM_BITS) << bmgs_pkg::LOG_FRAC)
                  - (64'(e_reg) << bmgs_pkg::LOG_FRAC) - 64'(frac_reg);
        r_round = acc_reg + (64'd1 << (SH - 1));
        fraw    = spare_ph_reg[29:0];
        quad    = spare_ph_reg[31:30];
        sp = swap_reg ? t_reg : sin_reg;
        cp = swap_reg ? sin_reg : t_reg;
        case (quad)
            2'd0: begin negv = 1'b0;          tsel = want_sin_reg ? sp : cp; end
            2'd1: begin negv = !want_sin_reg; tsel = want_sin_reg ? cp : sp; end
            2'd2: begin negv = 1'b1;          tsel = want_sin_reg ? sp : cp; end
            default: begin negv = want_sin_reg; tsel = want_sin_reg ? cp : sp; end
        endcase
        mag  = 33'((acc_reg + (64'd1 << 29)) >> 30);
        vsum = negv ? (35'sd0 - $signed({2'b0, mag})) : $signed({2'b0, mag});
        vsum = vsum + 35'($signed(mean_level));
        sq_sum = sq_res_reg + sq_bit_reg;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_LSQ:   begin mul_a = m_reg;           mul_b = m_reg; end
            S_LMUL:  begin mul_a = lval[31:0];      mul_b = bmgs_pkg::TWO_LN2_Q28; end
            S_LMUL2: begin mul_a = 32'(lval[63:32]); mul_b = bmgs_pkg::TWO_LN2_Q28; end
            S_VMUL:  begin mul_a = variance_level;  mul_b = spare_r_reg; end
            S_XMUL:  begin mul_a = {2'b0, f_reg};   mul_b = bmgs_pkg::HALF_PI_Q30; end
            S_X2:    begin mul_a = {1'b0, x_reg};   mul_b = {1'b0, x_reg}; end
            S_HMUL:  begin mul_a = {1'b0, x2_reg};  mul_b = {1'b0, t_reg}; end
            S_HDIV:  begin mul_a = acc_reg[61:30];  mul_b = div_recip; end
            S_SMUL:  begin mul_a = {1'b0, x_reg};   mul_b = {1'b0, t_reg}; end
            S_AMUL:  begin mul_a = amp_reg;         mul_b = {1'b0, tsel}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // main sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            spare_valid_reg <= 1'b0;
            spare_r_reg     <= '0;
            spare_ph_reg    <= '0;
            done_reg        <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        want_sin_reg <= spare_valid_reg;
                        if (spare_valid_reg) begin
                            spare_valid_reg <= 1'b0;
                            state_reg <= S_VMUL;
                        end else begin
                            spare_valid_reg <= 1'b1;
                            spare_ph_reg <= 32'(({32'd0, u_phase}
                                & ((64'd1 << UNIFORM_BITS) - 64'd1)) << (32 - UNIFORM_BITS));
                            e_reg    <= e_find;
                            m_reg    <= 32'(ux << (31 - e_find));
                            frac_reg <= '0;
                            it_reg   <= '0;
                            state_reg <= S_LSQ;
                        end
                    end
                end
                // one squaring of the mantissa per cycle
                S_LSQ: begin
                    if (mul_p[63]) begin
                        m_reg    <= mul_p[63:32];
                        frac_reg <= {frac_reg[26:0], 1'b1};
                    end else begin
                        m_reg    <= mul_p[62:31];
                        frac_reg <= {frac_reg[26:0], 1'b0};
                    end
                    it_reg <= it_reg + 5'd1;
                    if (it_reg == 5'(bmgs_pkg::LOG_FRAC - 1)) state_reg <= S_LMUL;
                end
                S_LMUL: begin
                    acc_reg   <= mul_p;
                    state_reg <= S_LMUL2;
                end
                S_LMUL2: begin
                    acc_reg   <= acc_reg + {mul_p[31:0], 32'd0};
                    state_reg <= S_LNORM;
                end
                S_LNORM: begin
                    spare_r_reg <= 32'(r_round >> SH);
                    state_reg   <= S_VMUL;
                end
                S_VMUL: begin
                    sq_v_reg   <= mul_p;
                    sq_res_reg <= '0;
                    sq_bit_reg <= 64'd1 << 62;
                    state_reg  <= S_SQRT;
                end
                // bit-serial square root
                S_SQRT: begin
                    if (sq_bit_reg == 64'd0) begin
                        amp_reg <= sq_res_reg[31:0];
                        if (fraw >= 30'h2000_0000) begin
                            f_reg <= 30'(31'h4000_0000 - {1'b0, fraw});
                            swap_reg <= 1'b1;
                        end else begin
                            f_reg <= fraw;
                            swap_reg <= 1'b0;
                        end
                        state_reg <= S_XMUL;
                    end else begin
                        if (sq_v_reg >= sq_sum) begin
                            sq_v_reg   <= sq_v_reg - sq_sum;
                            sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                        end else begin
                            sq_res_reg <= sq_res_reg >> 1;
                        end
                        sq_bit_reg <= sq_bit_reg >> 2;
                    end
                end
                S_XMUL: begin
                    x_reg     <= 31'(mul_p >> 30);
                    state_reg <= S_X2;
                end
                S_X2: begin
                    x2_reg       <= 31'(mul_p >> 30);
                    t_reg        <= bmgs_pkg::ONE_Q30;
                    cos_pass_reg <= 1'b0;
                    hidx_reg     <= '0;
                    state_reg    <= S_HMUL;
                end
                S_HMUL: begin
                    acc_reg   <= mul_p;
                    state_reg <= S_HDIV;
                end
                // quotient by reciprocal, then next Horner step or exit after the last
                S_HDIV: begin
                    t_reg <= 31'(bmgs_pkg::ONE_Q30 - div_q);
                    if (hidx_reg == (cos_pass_reg ? 3'd4 : 3'd3)) begin
                        state_reg <= cos_pass_reg ? S_AMUL : S_SMUL;
                    end else begin
                        hidx_reg  <= hidx_reg + 3'd1;
                        state_reg <= S_HMUL;
                    end
                end
                S_SMUL: begin
                    sin_reg      <= 31'(mul_p >> 30);
                    t_reg        <= bmgs_pkg::ONE_Q30;
                    cos_pass_reg <= 1'b1;
                    hidx_reg     <= '0;
                    state_reg    <= S_HMUL;
                end
                S_AMUL: begin
                    acc_reg   <= mul_p;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (vsum > 35'sh0_7FFF_FFFF) out_reg <= 32'h7FFF_FFFF;
                    else if (vsum < -35'sh0_8000_0000) out_reg <= 32'h8000_0000;
                    else out_reg <= vsum[31:0];
                    spare_out_reg <= want_sin_reg;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done       = done_reg;
    assign sample     = out_reg;
    assign spare_flag = spare_out_reg;
endmodule

>>> hw/rtl/bmgs_checker.sv
// Port-level checker for the Box-Muller sampler, bound to the top level.
// Depends on box_muller_gaussian_sampler_unit ports only.
module bmgs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_used_spare,
    input logic [31:0] m_gauss_sample
);
    // handshake outputs are always known
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown({s_ready, m_valid})) else $error("unknown handshake output");
    // accepted item blocks input next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("ready after accept");
    // result holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_gauss_sample)
        && $stable(m_used_spare))) else $error("result changed while stalled");
    // no output right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("valid after reset");
endmodule

bind box_muller_gaussian_sampler_unit bmgs_checker u_bmgs_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_used_spare(m_used_spare),
    .m_gauss_sample(m_gauss_sample)
);

>>> bench/box_muller_gaussian_sampler_unit_tb.sv
// Self-checking bench for the Box-Muller Gaussian sampler unit.
// Predicts every sample in fixed point; depends on bmgs_pkg and the unit RTL.
`timescale 1ns / 100ps

module box_muller_gaussian_sampler_unit_tb;

    localparam longint CYCLE_LIMIT = 500_000;

    typedef struct packed {
        logic [31:0] radius;
        logic [31:0] phase;
    } uniform_pair_t;

    typedef struct packed {
        logic [31:0] sample;
        logic        spare;
    } gauss_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = bmgs_pkg::REG_MEAN;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_uniform_radius = '0;
    logic [31:0] s_uniform_phase = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_gauss_sample;
    logic        m_used_spare;

    box_muller_gaussian_sampler_unit DUT (.*);

    always #10 aclk = ~aclk;

    // predictor state
    logic [31:0] pred_mean = 32'd0;
    logic [31:0] pred_var = 32'd65536;
    bit          pred_spare = 1'b0;
    logic [31:0] pred_log_r = '0;
    logic [31:0] pred_phase = '0;

    uniform_pair_t pending_pairs[$];
    gauss_result_t expected_samples[$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  error_count = 0;
    bit  stim_done = 1'b0;
    longint cycle_count = 0;

    function automatic longint unsigned log2_fix(longint unsigned x);
        int e;
        longint unsigned m, fr;
        e = 0;
        fr = 0;
        while (e < 63 && (x >> (e + 1)) != 0) e++;
        m = x << (31 - e);
        for (int i = 0; i < bmgs_pkg::LOG_FRAC; i++) begin
            m = (m * m) >> 31;
            fr = fr << 1;
            if (m >= 64'h1_0000_0000) begin
                fr |= 1;
                m = m >> 1;
            end
        end
        return (longint'(e) << bmgs_pkg::LOG_FRAC) | fr;
    endfunction

    function automatic logic [31:0] log_radius(logic [31:0] raw);
        longint unsigned x, l, p;
        x = raw;
        if (x == 0) x = 1;
        l = (longint'(32) << bmgs_pkg::LOG_FRAC) - log2_fix(x);
        p = l * bmgs_pkg::TWO_LN2_Q28;
        return 32'((p + (64'd1 << 39)) >> 40);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned poly(longint unsigned x2, bit is_cos, int n);
        longint unsigned t, one;
        one = 64'd1 << 30;
        t = one;
        for (int i = 0; i < n; i++) begin
            case (i)
                0: t = one - ((x2 * t) >> 30) / (is_cos ? 90 : 72);
                1: t = one - ((x2 * t) >> 30) / (is_cos ? 56 : 42);
                2: t = one - ((x2 * t) >> 30) / (is_cos ? 30 : 20);
                3: t = one - ((x2 * t) >> 30) / (is_cos ? 12 : 6);
                default: t = one - ((x2 * t) >> 30) / 2;
            endcase
        end
        return t;
    endfunction

    function automatic logic [31:0] gauss_value(logic [31:0] r, logic [31:0] ph, bit want_sin);
        longint unsigned amp, f, x, x2, s, c, sp, cp, t, mag;
        longint v;
        bit swap, neg;
        amp = int_sqrt(longint'(pred_var) * longint'(r));
        f = ph[29:0];
        swap = 1'b0;
        if (f >= (64'd1 << 29)) begin
            f = (64'd1 << 30) - f;
            swap = 1'b1;
        end
        x = (f * bmgs_pkg::HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        s = (x * poly(x2, 1'b0, 4)) >> 30;
        c = poly(x2, 1'b1, 5);
        sp = swap ? c : s;
        cp = swap ? s : c;
        case (ph[31:30])
            2'd0: begin neg = 0; t = want_sin ? sp : cp; end
            2'd1: begin neg = !want_sin; t = want_sin ? cp : sp; end
            2'd2: begin neg = 1; t = want_sin ? sp : cp; end
            default: begin neg = want_sin; t = want_sin ? cp : sp; end
        endcase
        mag = (amp * t + (64'd1 << 29)) >> 30;
        v = (neg ? -longint'(mag) : longint'(mag)) + longint'($signed(pred_mean));
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic gauss_result_t predict_sample(uniform_pair_t u);
        gauss_result_t g;
        if (pred_spare) begin
            pred_spare = 1'b0;
            g.sample = gauss_value(pred_log_r, pred_phase, 1'b1);
            g.spare = 1'b1;
        end else begin
            pred_log_r = log_radius(u.radius);
            pred_phase = u.phase;
            pred_spare = 1'b1;
            g.sample = gauss_value(pred_log_r, pred_phase, 1'b0);
            g.spare = 1'b0;
        end
        return g;
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_uniform_radius <= pending_pairs[0].radius;
                    s_uniform_phase <= pending_pairs[0].phase;
                    void'(pending_pairs.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // prediction on accept, checking on output transaction
    always @(posedge aclk) begin
        gauss_result_t exp_r;
        cycle_count++;
        if (aresetn && s_valid && s_ready)
            expected_samples.push_back(predict_sample({s_uniform_radius, s_uniform_phase}));
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected transaction: gauss_sample %h", m_gauss_sample);
                error_count++;
            end else begin
                exp_r = expected_samples.pop_front();
                if (m_gauss_sample !== exp_r.sample) begin
                    $error("gauss_sample expected %h actual %h", exp_r.sample, m_gauss_sample);
                    error_count++;
                end
                if (m_used_spare !== exp_r.spare) begin
                    $error("used_spare expected %b actual %b", exp_r.spare, m_used_spare);
                    error_count++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || s_valid || expected_samples.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == bmgs_pkg::REG_MEAN) pred_mean = val;
        else pred_var = val;
    endtask

    task automatic queue_random(int n);
        uniform_pair_t u;
        for (int i = 0; i < n; i++) begin
            u.radius = $urandom();
            u.phase = $urandom();
            // small radius values reach the deep tail
            if ($urandom_range(9) == 0) u.radius = $urandom_range(255);
            pending_pairs.push_back(u);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, zero radius clamp, quadrant edges
        pending_pairs.push_back('{32'd0, 32'd0});
        pending_pairs.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
        pending_pairs.push_back('{32'hFFFF_FFFF, 32'h4000_0000});
        pending_pairs.push_back('{32'h0000_0001, 32'h2000_0000});
        pending_pairs.push_back('{32'h8000_0000, 32'h8000_0000});
        pending_pairs.push_back('{32'h0000_0000, 32'hC000_0000});
        pending_pairs.push_back('{32'h1234_5678, 32'h1FFF_FFFF});
        pending_pairs.push_back('{32'h5555_5555, 32'hAAAA_AAAA});
        pending_pairs.push_back('{32'hAAAA_AAAA, 32'h5555_5555});
        pending_pairs.push_back('{32'h0000_0000, 32'h6000_0000});
        wait_drained();
        write_reg(bmgs_pkg::REG_VARIANCE, 32'hFFFF_FFFF);
        write_reg(bmgs_pkg::REG_MEAN, 32'h7FFF_FFFF);
        pending_pairs.push_back('{32'd0, 32'd0});
        pending_pairs.push_back('{32'd0, 32'h8000_0000});
        queue_random(4);
        wait_drained();
        write_reg(bmgs_pkg::REG_MEAN, 32'h8000_0000);
        pending_pairs.push_back('{32'd0, 32'h8000_0000});
        pending_pairs.push_back('{32'd5, 32'h0});
        queue_random(4);
        wait_drained();
        write_reg(bmgs_pkg::REG_VARIANCE, 32'd0);
        write_reg(bmgs_pkg::REG_MEAN, 32'hFFFF_0000);
        queue_random(4);
        wait_drained();

        // random phases with varying configuration and flow control
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(bmgs_pkg::REG_MEAN, $urandom());
            write_reg(bmgs_pkg::REG_VARIANCE,
                      ph == 3 ? 32'd65536 : $urandom_range(32'h0100_0000));
            send_idle_pct = (ph == 1 || ph == 3) ? 59 : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? 59 : 0;
            if (ph == 3) begin
                send_idle_pct = 10;
                recv_stall_pct = 10;
            end
            queue_random(155);
            wait_drained();
        end

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/bmgs_pkg.sv
hw/rtl/bmgs_divider.sv
hw/rtl/bmgs_core.sv
hw/rtl/box_muller_gaussian_sampler_unit.sv
hw/rtl/bmgs_checker.sv
bench/box_muller_gaussian_sampler_unit_tb.sv
